FILE: rtl/drpbr_pkg.sv
`default_nettype none

package drpbr_pkg;

  // Fixed widths of the request and result fields.
  localparam int TIME_BITS     = 48;
  localparam int BANKS         = 16;
  localparam int BANK_BITS     = $clog2(BANKS);
  localparam int INTERVAL_BITS = 20;
  localparam int LIMIT_BITS    = 8;
  localparam int CREDIT_BITS   = 10;
  localparam int CFG_DATA_BITS = 48;

  typedef logic [TIME_BITS-1:0]     stamp_t;
  typedef logic [BANKS-1:0]         bank_mask_t;
  typedef logic [BANK_BITS-1:0]     bank_idx_t;
  typedef logic [INTERVAL_BITS-1:0] interval_t;
  typedef logic [LIMIT_BITS-1:0]    limit_t;
  typedef logic signed [CREDIT_BITS-1:0] credit_t;

  // Reset values of the configuration registers.
  localparam interval_t RST_REFRESH_INTERVAL = interval_t'(3900);
  localparam stamp_t    RST_FIRST_TRIGGER    = stamp_t'(3900);
  localparam limit_t    RST_MAX_POSTPONED    = limit_t'(128);
  localparam limit_t    RST_MAX_PULLED_IN    = limit_t'(128);

  localparam stamp_t     TIME_NEVER = '1;
  localparam bank_mask_t ALL_BANKS  = '1;
  localparam credit_t    CREDIT_MAX = credit_t'(511);
  localparam credit_t    CREDIT_MIN = credit_t'(-512);

  typedef enum logic {
    CMD_EVALUATE = 1'b0,
    CMD_NOTIFY   = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ISSUED_OTHER    = 3'd0,
    ISSUED_REFB     = 3'd1,
    ISSUED_REFA     = 3'd2,
    ISSUED_PD_ENTRY = 3'd3,
    ISSUED_SR_ENTRY = 3'd4,
    ISSUED_PD_EXIT  = 3'd5
  } issued_t;

  typedef enum logic [1:0] {
    NEXT_NONE = 2'd0,
    NEXT_PRE  = 2'd1,
    NEXT_REFB = 2'd2
  } next_cmd_t;

  typedef enum logic [1:0] {
    CFG_REFRESH_INTERVAL = 2'd0,
    CFG_FIRST_TRIGGER    = 2'd1,
    CFG_MAX_POSTPONED    = 2'd2,
    CFG_MAX_PULLED_IN    = 2'd3
  } cfg_index_t;

  typedef struct packed {
    cmd_t       cmd;
    stamp_t     now;
    bank_mask_t bank_idle;
    bank_mask_t bank_open;
    issued_t    issued_cmd;
  } req_t;

  typedef struct packed {
    next_cmd_t next_cmd;
    bank_idx_t bank;
    logic      block_bank;
    logic      interrupt_powerdown;
    stamp_t    wake_time;
  } res_t;

  // Saturating time addition: an overflow means never.
  function automatic stamp_t sat_add(stamp_t a, logic [INTERVAL_BITS:0] b);
    logic [TIME_BITS:0] s;
    begin
      s = {1'b0, a} + {{(TIME_BITS-INTERVAL_BITS){1'b0}}, b};
      sat_add = s[TIME_BITS] ? TIME_NEVER : s[TIME_BITS-1:0];
    end
  endfunction

  // Index of the lowest set bit, zero for an empty mask.
  function automatic bank_idx_t lowest_bit(bank_mask_t m);
    bank_idx_t idx;
    begin
      idx = '0;
      for (int i = BANKS - 1; i >= 0; i--) begin
        if (m[i]) begin
          idx = bank_idx_t'(i);
        end
      end
      lowest_bit = idx;
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/drpbr_in_stage.sv
`default_nettype none

module drpbr_in_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire drpbr_pkg::req_t req,
  output logic                item_valid,
  input  wire logic           item_take,
  output drpbr_pkg::req_t     item
);

  logic valid;

  // The register frees up when it is empty or its request is taken this cycle.
  assign req_ready  = !valid || item_take;
  assign item_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (req_ready) begin
      valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drpbr_out_stage.sv
`default_nettype none

module drpbr_out_stage (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  output logic                load_ready,
  input  wire drpbr_pkg::res_t result,
  output logic                res_valid,
  input  wire logic           res_ready,
  output drpbr_pkg::res_t     res
);

  logic valid;

  // A new result may enter while the held one leaves.
  assign load_ready = !valid || res_ready;
  assign res_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ready) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      res <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/drpbr_core.sv
`default_nettype none

module drpbr_core (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire drpbr_pkg::cfg_index_t                 cfg_index,
  input  wire logic [drpbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  wire logic                                  fire,
  input  wire drpbr_pkg::req_t                       item,
  output drpbr_pkg::res_t                            result
);

  // Configuration registers.
  drpbr_pkg::interval_t refresh_interval;
  drpbr_pkg::limit_t    max_postponed;
  drpbr_pkg::limit_t    max_pulled_in;

  // Scheduler state.
  drpbr_pkg::stamp_t     next_trigger_time, next_trigger_time_next;
  logic                  pulled_in_mode, pulled_in_mode_next;
  drpbr_pkg::credit_t    credit_count, credit_count_next;
  drpbr_pkg::bank_mask_t remaining_banks, remaining_banks_next;
  drpbr_pkg::bank_idx_t  selected_bank, selected_bank_next;
  logic                  skip_selection, skip_selection_next;
  logic                  sleeping, sleeping_next;

  // Trigger times one and two intervals ahead, and the notify reload time.
  drpbr_pkg::stamp_t     trig_p1;
  drpbr_pkg::stamp_t     trig_p2;
  drpbr_pkg::stamp_t     now_plus;
  logic                  late;
  logic                  forced;
  logic                  busy;
  drpbr_pkg::bank_mask_t cand;
  drpbr_pkg::bank_mask_t rem_cleared;
  drpbr_pkg::credit_t    credit_dec;
  drpbr_pkg::credit_t    pull_limit;

  assign trig_p1  = drpbr_pkg::sat_add(next_trigger_time, {1'b0, refresh_interval});
  assign trig_p2  = drpbr_pkg::sat_add(next_trigger_time, {refresh_interval, 1'b0});
  assign now_plus = drpbr_pkg::sat_add(item.now, {1'b0, refresh_interval});
  assign late     = item.now >= trig_p1;
  assign cand     = remaining_banks & item.bank_idle;
  assign forced   = credit_count == $signed({2'b00, max_postponed});
  assign pull_limit  = drpbr_pkg::credit_t'(0) - $signed({2'b00, max_pulled_in});
  assign rem_cleared = remaining_banks & ~(drpbr_pkg::bank_mask_t'(1) << selected_bank);
  assign credit_dec  = (credit_count != drpbr_pkg::CREDIT_MIN) ?
                       credit_count - drpbr_pkg::credit_t'(1) : credit_count;

  // Per-request decision and state update.
  always_comb begin
    next_trigger_time_next = next_trigger_time;
    pulled_in_mode_next    = pulled_in_mode;
    credit_count_next      = credit_count;
    remaining_banks_next   = remaining_banks;
    selected_bank_next     = selected_bank;
    skip_selection_next    = skip_selection;
    sleeping_next          = sleeping;
    busy                   = 1'b1;
    result.next_cmd            = drpbr_pkg::NEXT_NONE;
    result.block_bank          = 1'b0;
    result.interrupt_powerdown = 1'b0;
    result.wake_time           = next_trigger_time;

    if (item.cmd == drpbr_pkg::CMD_NOTIFY) begin
      unique case (item.issued_cmd)
        drpbr_pkg::ISSUED_REFB: begin
          skip_selection_next  = 1'b0;
          remaining_banks_next = (rem_cleared == '0) ? drpbr_pkg::ALL_BANKS : rem_cleared;
          if (pulled_in_mode) begin
            credit_count_next = credit_dec;
          end else begin
            pulled_in_mode_next = 1'b1;
          end
          if (credit_count_next == pull_limit) begin
            pulled_in_mode_next    = 1'b0;
            next_trigger_time_next = trig_p1;
          end
        end
        drpbr_pkg::ISSUED_REFA: begin
          pulled_in_mode_next    = 1'b0;
          next_trigger_time_next = now_plus;
          sleeping_next          = 1'b0;
        end
        drpbr_pkg::ISSUED_PD_ENTRY: begin
          sleeping_next = 1'b1;
        end
        drpbr_pkg::ISSUED_SR_ENTRY: begin
          sleeping_next          = 1'b1;
          next_trigger_time_next = drpbr_pkg::TIME_NEVER;
        end
        drpbr_pkg::ISSUED_PD_EXIT: begin
          sleeping_next = 1'b0;
        end
        default: begin
        end
      endcase
      result.wake_time = next_trigger_time_next;
    end else if (item.now >= next_trigger_time) begin
      result.interrupt_powerdown = 1'b1;
      result.wake_time           = drpbr_pkg::TIME_NEVER;
      if (!sleeping) begin
        // A whole interval missed: move the trigger on and leave pull-in.
        if (late) begin
          next_trigger_time_next = trig_p1;
          pulled_in_mode_next    = 1'b0;
        end
        if (!pulled_in_mode_next) begin
          if (!skip_selection) begin
            if (remaining_banks != '0) begin
              selected_bank_next = drpbr_pkg::lowest_bit(remaining_banks);
            end
            if (cand != '0) begin
              selected_bank_next = drpbr_pkg::lowest_bit(cand);
              busy               = 1'b0;
            end
          end
          if (busy && !forced) begin
            // Postpone by one interval.
            if (credit_count != drpbr_pkg::CREDIT_MAX) begin
              credit_count_next = credit_count + drpbr_pkg::credit_t'(1);
            end
            next_trigger_time_next = late ? trig_p2 : trig_p1;
            result.wake_time       = next_trigger_time_next;
          end else begin
            result.wake_time = '0;
            if (item.bank_open[selected_bank_next]) begin
              result.next_cmd = drpbr_pkg::NEXT_PRE;
            end else begin
              result.next_cmd = drpbr_pkg::NEXT_REFB;
              if (forced) begin
                result.block_bank   = 1'b1;
                skip_selection_next = 1'b1;
              end
            end
          end
        end else begin
          // Pulled-in mode only goes on while an idle bank is pending.
          if (cand == '0) begin
            pulled_in_mode_next    = 1'b0;
            next_trigger_time_next = trig_p1;
            result.wake_time       = trig_p1;
          end else begin
            selected_bank_next = drpbr_pkg::lowest_bit(cand);
            result.wake_time   = '0;
            result.next_cmd    = item.bank_open[selected_bank_next] ?
                                 drpbr_pkg::NEXT_PRE : drpbr_pkg::NEXT_REFB;
          end
        end
      end
    end
    result.bank = selected_bank_next;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_interval <= drpbr_pkg::RST_REFRESH_INTERVAL;
      max_postponed    <= drpbr_pkg::RST_MAX_POSTPONED;
      max_pulled_in    <= drpbr_pkg::RST_MAX_PULLED_IN;
    end else if (cfg_we) begin
      unique case (cfg_index)
        drpbr_pkg::CFG_REFRESH_INTERVAL: begin
          refresh_interval <= cfg_data[drpbr_pkg::INTERVAL_BITS-1:0];
        end
        drpbr_pkg::CFG_MAX_POSTPONED: begin
          max_postponed <= cfg_data[drpbr_pkg::LIMIT_BITS-1:0];
        end
        drpbr_pkg::CFG_MAX_PULLED_IN: begin
          max_pulled_in <= cfg_data[drpbr_pkg::LIMIT_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // State registers; writing the first trigger also reloads the trigger time.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_trigger_time <= drpbr_pkg::RST_FIRST_TRIGGER;
      pulled_in_mode    <= 1'b0;
      credit_count      <= '0;
      remaining_banks   <= drpbr_pkg::ALL_BANKS;
      selected_bank     <= '0;
      skip_selection    <= 1'b0;
      sleeping          <= 1'b0;
    end else if (cfg_we && cfg_index == drpbr_pkg::CFG_FIRST_TRIGGER) begin
      next_trigger_time <= cfg_data[drpbr_pkg::TIME_BITS-1:0];
    end else if (fire) begin
      next_trigger_time <= next_trigger_time_next;
      pulled_in_mode    <= pulled_in_mode_next;
      credit_count      <= credit_count_next;
      remaining_banks   <= remaining_banks_next;
      selected_bank     <= selected_bank_next;
      skip_selection    <= skip_selection_next;
      sleeping          <= sleeping_next;
    end
  end

  // The round mask refills as soon as its last bank is refreshed.
  a_round_not_empty: assert property (@(posedge clk) disable iff (rst)
    remaining_banks != '0)
    else $error("refresh round mask is empty");

  // A command never comes with a wake time.
  a_cmd_no_wake: assert property (@(posedge clk) disable iff (rst)
    fire && result.next_cmd != drpbr_pkg::NEXT_NONE |-> result.wake_time == '0)
    else $error("command issued with nonzero wake time");

  // A forced refresh locks the selection on the bank that it names.
  a_forced_locks: assert property (@(posedge clk) disable iff (rst)
    fire && result.block_bank |=> skip_selection && selected_bank == $past(result.bank))
    else $error("forced refresh did not lock the selected bank");

  // No command is requested while the device sleeps.
  a_sleep_quiet: assert property (@(posedge clk) disable iff (rst)
    fire && sleeping && item.cmd == drpbr_pkg::CMD_EVALUATE
    |-> result.next_cmd == drpbr_pkg::NEXT_NONE)
    else $error("command requested while sleeping");

endmodule

`default_nettype wire

FILE: rtl/dram_per_bank_refresh_scheduler_unit.sv
`default_nettype none

// Per-bank DRAM refresh scheduler with postpone and pull-in credits. Each request
// is either an evaluate (time, idle and open bank masks) or a notify of an issued
// command, and gives exactly one result. A request passes an input register,
// combinational decision logic that also updates the scheduler state, and a
// result register, from which the result is presented; one request is taken
// every cycle as long as results are taken. The state update between consecutive
// requests sets that rate. Configuration writes take effect at once and are meant
// for times when no request is in flight.
module dram_per_bank_refresh_scheduler_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_ready,
  input  wire drpbr_pkg::req_t                     req,
  output logic                                     res_valid,
  input  wire logic                                res_ready,
  output drpbr_pkg::res_t                          res,
  input  wire logic                                cfg_we,
  input  wire drpbr_pkg::cfg_index_t               cfg_index,
  input  wire logic [drpbr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  logic            item_valid;
  logic            load_ready;
  logic            fire;
  drpbr_pkg::req_t item;
  drpbr_pkg::res_t result;

  // A held request is decided when the result register can take it.
  assign fire = item_valid && load_ready;

  drpbr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .item_valid (item_valid),
    .item_take  (fire),
    .item       (item)
  );

  drpbr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  drpbr_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (item_valid),
    .load_ready (load_ready),
    .result     (result),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

endmodule

`default_nettype wire

FILE: bench/refresh_checker.sv
// Watches both channels of the refresh scheduler, keeps its own copy of the
// scheduler state and compares every result with the oldest prediction.
module refresh_checker
  import drpbr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic                     req_ready,
  input  req_t                     req,
  input  logic                     res_valid,
  input  logic                     res_ready,
  input  res_t                     res,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       fail_count,
  output int                       outstanding,
  output int                       results_seen,
  output int                       precharges,
  output int                       refreshes,
  output int                       forced_refreshes
);

  // Shadow copy of the configuration registers.
  interval_t  interval_reg;
  limit_t     postpone_limit;
  limit_t     pullin_limit;

  // Shadow scheduler state.
  stamp_t     trigger_time;
  logic       pulled_in;
  int         credit;
  bank_mask_t round_left;
  bank_idx_t  target_bank;
  logic       hold_target;
  logic       asleep;

  // Predicted results, oldest first.
  res_t       expected_q[$];

  // Time addition that sticks at the "never" value on overflow.
  function automatic stamp_t stamp_plus(stamp_t a, stamp_t b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? TIME_NEVER : sum[TIME_BITS-1:0];
  endfunction

  function automatic bank_idx_t lowest_pending(bank_mask_t m);
    for (int i = 0; i < BANKS; i++) begin
      if (m[i]) begin
        return bank_idx_t'(i);
      end
    end
    return '0;
  endfunction

  // Works out the result of one request and advances the shadow state.
  task automatic predict_refresh(input req_t r, output res_t o);
    bank_mask_t cand;
    stamp_t     step;
    logic       forced;
    logic       busy;
    o = '0;
    step = stamp_t'(interval_reg);
    if (r.cmd == CMD_NOTIFY) begin
      case (r.issued_cmd)
        ISSUED_REFB: begin
          // The selected bank is done for this round; an empty round refills.
          hold_target = 1'b0;
          round_left[target_bank] = 1'b0;
          if (round_left == '0) begin
            round_left = ALL_BANKS;
          end
          if (pulled_in) begin
            if (credit > -512) begin
              credit--;
            end
          end else begin
            pulled_in = 1'b1;
          end
          if (credit == -int'(pullin_limit)) begin
            pulled_in = 1'b0;
            trigger_time = stamp_plus(trigger_time, step);
          end
        end
        ISSUED_REFA: begin
          pulled_in = 1'b0;
          trigger_time = stamp_plus(r.now, step);
          asleep = 1'b0;
        end
        ISSUED_PD_ENTRY: begin
          asleep = 1'b1;
        end
        ISSUED_SR_ENTRY: begin
          asleep = 1'b1;
          trigger_time = TIME_NEVER;
        end
        ISSUED_PD_EXIT: begin
          asleep = 1'b0;
        end
        default: begin
        end
      endcase
      o.wake_time = trigger_time;
    end else if (r.now < trigger_time) begin
      o.wake_time = trigger_time;
    end else begin
      o.interrupt_powerdown = 1'b1;
      o.wake_time = TIME_NEVER;
      if (!asleep) begin
        cand = round_left & r.bank_idle;
        // A whole interval overdue drops pull-in and moves the trigger on.
        if (r.now >= stamp_plus(trigger_time, step)) begin
          trigger_time = stamp_plus(trigger_time, step);
          pulled_in = 1'b0;
        end
        if (!pulled_in) begin
          forced = (credit == int'(postpone_limit));
          busy = 1'b1;
          if (!hold_target) begin
            if (round_left != '0) begin
              target_bank = lowest_pending(round_left);
            end
            if (cand != '0) begin
              target_bank = lowest_pending(cand);
              busy = 1'b0;
            end
          end
          if (busy && !forced) begin
            // Postpone: one more credit and the trigger one interval later.
            if (credit < 511) begin
              credit++;
            end
            trigger_time = stamp_plus(trigger_time, step);
            o.wake_time = trigger_time;
          end else begin
            o.wake_time = '0;
            if (r.bank_open[target_bank]) begin
              o.next_cmd = NEXT_PRE;
            end else begin
              o.next_cmd = NEXT_REFB;
              if (forced) begin
                o.block_bank = 1'b1;
                hold_target = 1'b1;
              end
            end
          end
        end else begin
          if (cand == '0) begin
            pulled_in = 1'b0;
            trigger_time = stamp_plus(trigger_time, step);
            o.wake_time = trigger_time;
          end else begin
            target_bank = lowest_pending(cand);
            o.wake_time = '0;
            o.next_cmd = r.bank_open[target_bank] ? NEXT_PRE : NEXT_REFB;
          end
        end
      end
    end
    o.bank = target_bank;
  endtask

  task automatic compare_field(input string name, input logic [TIME_BITS-1:0] want,
                               input logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Register writes, request predictions and result checks, all at the rising edge.
  always @(posedge clk) begin
    res_t predicted;
    res_t oldest;
    if (rst) begin
      interval_reg   = RST_REFRESH_INTERVAL;
      postpone_limit = RST_MAX_POSTPONED;
      pullin_limit   = RST_MAX_PULLED_IN;
      trigger_time   = RST_FIRST_TRIGGER;
      pulled_in      = 1'b0;
      credit         = 0;
      round_left     = ALL_BANKS;
      target_bank    = '0;
      hold_target    = 1'b0;
      asleep         = 1'b0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REFRESH_INTERVAL: interval_reg = cfg_data[INTERVAL_BITS-1:0];
          CFG_FIRST_TRIGGER:    trigger_time = cfg_data[TIME_BITS-1:0];
          CFG_MAX_POSTPONED:    postpone_limit = cfg_data[LIMIT_BITS-1:0];
          CFG_MAX_PULLED_IN:    pullin_limit = cfg_data[LIMIT_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (req_valid && req_ready) begin
        predict_refresh(req, predicted);
        expected_q.insert(expected_q.size(), predicted);
      end
      if (res_valid && res_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          oldest = expected_q.pop_front();
          compare_field("next_cmd", TIME_BITS'(oldest.next_cmd), TIME_BITS'(res.next_cmd));
          compare_field("bank", TIME_BITS'(oldest.bank), TIME_BITS'(res.bank));
          compare_field("block_bank", TIME_BITS'(oldest.block_bank),
                        TIME_BITS'(res.block_bank));
          compare_field("interrupt_powerdown", TIME_BITS'(oldest.interrupt_powerdown),
                        TIME_BITS'(res.interrupt_powerdown));
          compare_field("wake_time", oldest.wake_time, res.wake_time);
          if (oldest.next_cmd == NEXT_PRE) begin
            precharges++;
          end
          if (oldest.next_cmd == NEXT_REFB) begin
            refreshes++;
          end
          if (oldest.block_bank) begin
            forced_refreshes++;
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

FILE: bench/tb_top.sv
// Drives requests and register writes into the refresh scheduler, stalls the
// result side at random and gives the verdict from the checker's counts.
module tb_top;
  import drpbr_pkg::*;

  // Issued-command codes that the scheduler has to ignore.
  localparam logic [2:0] ISSUED_SPARE_LO = 3'd6;
  localparam logic [2:0] ISSUED_SPARE_HI = 3'd7;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_ready;
  req_t                     req = '0;
  logic                     res_valid;
  logic                     res_ready = 1'b0;
  res_t                     res;
  logic                     cfg_we = 1'b0;
  cfg_index_t               cfg_index = CFG_REFRESH_INTERVAL;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int fail_count;
  int outstanding;
  int results_seen;
  int precharges;
  int refreshes;
  int forced_refreshes;

  // Stimulus state: no-gap stretches, running time stamp, current interval.
  logic   calm = 1'b0;
  stamp_t t_now = '0;
  int     cur_interval = 3900;
  int     sent = 0;

  dram_per_bank_refresh_scheduler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  refresh_checker u_checker (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_ready        (req_ready),
    .req              (req),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .results_seen     (results_seen),
    .precharges       (precharges),
    .refreshes        (refreshes),
    .forced_refreshes (forced_refreshes)
  );

  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5000000;
    $display("dram_per_bank_refresh_scheduler_unit: mismatch");
    $finish;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  function automatic bank_mask_t rand_mask();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return ALL_BANKS;
      default: return bank_mask_t'($urandom);
    endcase
  endfunction

  function automatic req_t request_of(cmd_t c, stamp_t stamp, bank_mask_t idle,
                                      bank_mask_t open, issued_t iss);
    req_t r;
    r.cmd = c;
    r.now = stamp;
    r.bank_idle = idle;
    r.bank_open = open;
    r.issued_cmd = iss;
    return r;
  endfunction

  // Mostly evaluates on a time line that moves forward by up to two intervals,
  // with refresh notifies after them, some other notifies and stray time stamps.
  function automatic req_t random_request();
    req_t               r;
    logic [TIME_BITS:0] sum;
    int                 pick;
    r.bank_idle = rand_mask();
    r.bank_open = rand_mask();
    r.issued_cmd = issued_t'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.cmd = CMD_EVALUATE;
      if ($urandom_range(0, 39) == 0) begin
        r.now = stamp_t'({$urandom, $urandom});
      end else begin
        sum = {1'b0, t_now} + (TIME_BITS + 1)'($urandom_range(0, 2 * cur_interval));
        t_now = sum[TIME_BITS] ? TIME_NEVER : sum[TIME_BITS-1:0];
        r.now = t_now;
      end
    end else begin
      r.cmd = CMD_NOTIFY;
      r.now = t_now;
      if (pick < 85) begin
        r.issued_cmd = ISSUED_REFB;
      end else if ($urandom_range(0, 2) == 0) begin
        r.issued_cmd = ISSUED_REFA;
      end
    end
    return r;
  endfunction

  // Presents one request after a random gap and holds it until it is taken.
  task automatic send_req(input req_t r);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = r;
    req_valid = 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Lets every outstanding request come back before registers change.
  task automatic drain_requests();
    @(negedge clk);
    req_valid = 1'b0;
    wait (outstanding == 0);
    repeat (3) @(negedge clk);
  endtask

  // Result side: a fresh random stall before each result.
  initial begin
    int gap;
    forever begin
      gap = draw_gap();
      @(negedge clk);
      if (gap > 0) begin
        res_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ready = 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  initial begin
    req_t      r;
    interval_t ivl;
    stamp_t    first;
    limit_t    pp;
    limit_t    pi;
    int        count;
    int        quota;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset settings.
    send_req(request_of(CMD_EVALUATE, '0, ALL_BANKS, '0, ISSUED_OTHER));
    send_req(request_of(CMD_EVALUATE, 3900, ALL_BANKS, '0, ISSUED_OTHER));
    send_req(request_of(CMD_NOTIFY, 3900, '0, '0, ISSUED_REFB));
    // Pulled-in refresh of an open bank asks for a precharge first.
    send_req(request_of(CMD_EVALUATE, 3901, 16'hFFFE, 16'h0002, ISSUED_OTHER));
    send_req(request_of(CMD_NOTIFY, 3901, '0, '0, ISSUED_OTHER));
    send_req(request_of(CMD_EVALUATE, 3902, 16'hFFFE, '0, ISSUED_OTHER));
    send_req(request_of(CMD_NOTIFY, 3902, '0, '0, ISSUED_REFB));
    // No idle bank while pulling in ends the pull-in.
    send_req(request_of(CMD_EVALUATE, 3903, '0, ALL_BANKS, ISSUED_OTHER));
    // Far overdue, only the top bank idle and open.
    send_req(request_of(CMD_EVALUATE, 20000, 16'h8000, 16'h8000, ISSUED_OTHER));
    send_req(request_of(CMD_EVALUATE, 20001, '0, '0, ISSUED_OTHER));
    // Sleeping past the trigger only raises the interrupt.
    send_req(request_of(CMD_NOTIFY, 20001, '0, '0, ISSUED_PD_ENTRY));
    send_req(request_of(CMD_EVALUATE, TIME_NEVER, ALL_BANKS, '0, ISSUED_OTHER));
    send_req(request_of(CMD_NOTIFY, TIME_NEVER, '0, '0, ISSUED_PD_EXIT));
    // Self-refresh pushes the trigger to never; a full refresh at the top saturates.
    send_req(request_of(CMD_NOTIFY, 20002, '0, '0, ISSUED_SR_ENTRY));
    send_req(request_of(CMD_EVALUATE, TIME_NEVER - 1, ALL_BANKS, '0, ISSUED_OTHER));
    send_req(request_of(CMD_NOTIFY, TIME_NEVER, ALL_BANKS, ALL_BANKS, ISSUED_REFA));
    send_req(request_of(CMD_EVALUATE, TIME_NEVER, ALL_BANKS, ALL_BANKS, ISSUED_OTHER));
    // Undefined issued codes are ignored.
    send_req(request_of(CMD_NOTIFY, '0, '0, '0, issued_t'(ISSUED_SPARE_LO)));
    send_req(request_of(CMD_NOTIFY, '0, '0, '0, issued_t'(ISSUED_SPARE_HI)));
    send_req(request_of(CMD_NOTIFY, 100, '0, '0, ISSUED_REFA));
    send_req(request_of(CMD_EVALUATE, 4000, 16'h5555, 16'hAAAA, ISSUED_OTHER));
    drain_requests();

    // Random phases, each with its own register settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          ivl = 1;
          first = '0;
          pp = '0;
          pi = '0;
        end
        1: begin
          ivl = '1;
          first = TIME_NEVER - 5;
          pp = '1;
          pi = '1;
        end
        2: begin
          ivl = interval_t'($urandom_range(2, 64));
          first = stamp_t'($urandom_range(0, 500));
          pp = '1;
          pi = '1;
        end
        default: begin
          ivl = interval_t'($urandom_range(1, 200));
          first = stamp_t'($urandom_range(0, 2000));
          pp = limit_t'($urandom_range(0, 8));
          pi = limit_t'($urandom_range(0, 8));
        end
      endcase
      write_cfg(CFG_REFRESH_INTERVAL, CFG_DATA_BITS'(ivl));
      write_cfg(CFG_FIRST_TRIGGER, CFG_DATA_BITS'(first));
      write_cfg(CFG_MAX_POSTPONED, CFG_DATA_BITS'(pp));
      write_cfg(CFG_MAX_PULLED_IN, CFG_DATA_BITS'(pi));
      cur_interval = int'(ivl);
      t_now = (first > stamp_t'(ivl)) ? first - stamp_t'($urandom_range(0, cur_interval)) : '0;
      calm = ($urandom_range(0, 3) == 0);
      quota = (phase == 1) ? 60 : 150;
      count = 0;
      while (count < quota) begin
        r = random_request();
        send_req(r);
        // Ignored notifies do not count toward the phase.
        if (!(r.cmd == CMD_NOTIFY && r.issued_cmd > ISSUED_PD_EXIT)) begin
          count++;
          if (count % 40 == 0) begin
            calm = ($urandom_range(0, 2) == 0);
          end
        end
      end
      drain_requests();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d requests: a directed set, then eight random register settings.",
             sent);
    $display("Checked %0d results: %0d precharges, %0d refreshes, %0d of them forced.",
             results_seen, precharges, refreshes, forced_refreshes);
    if (fail_count == 0 && outstanding == 0) begin
      $display("dram_per_bank_refresh_scheduler_unit: match");
    end else begin
      $display("dram_per_bank_refresh_scheduler_unit: mismatch");
    end
    $finish;
  end

endmodule
